>>> hdl/bfa_pkg.sv
// Shared types and constants for the bitmap first-fit allocator.
`default_nettype none

package bfa_pkg;

  // Widths of the entry number, count and status fields
  localparam int FIELD_W   = 14;
  localparam int STATUS_W  = 2;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam int CFG_IDX_W = 1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 1'b1;

  localparam logic [FIELD_W-1:0] COUNT_MAX       = 14'd16383;
  localparam logic [FIELD_W-1:0] ENTRY_COUNT_RST = 14'd8192;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR
  } bfa_state_t;

endpackage : bfa_pkg

`default_nettype wire

>>> hdl/bitmap_first_fit_allocator.sv
// Top level of the bitmap first-fit allocator: sequencer, bitmap RAM and use counter.
`default_nettype none

// Usage
//   Command channel: drive start with in_kind/in_index; a beat is taken at a
//   clock edge with start high and busy low. in_kind 0 allocates the lowest
//   free entry, 1 frees entry number in_index.
//   Result channel: out_valid strobes for exactly one cycle per beat with
//   out_status, out_index_res and out_used_count. The receiver cannot stall.
//   Config channel: cfg_valid/cfg_ready write cfg_wdata into register
//   cfg_index (0 entry_count, 1 number_base). Write only while idle.
// Operation
//   The bitmap lives in a RAM of 32-bit words with one read and one write
//   port. An allocate streams one word per cycle through a single find-first-
//   zero unit, reading the words up to and including the first word holding
//   a free bit (at most ceil(limit / 32) words). A valid free is a
//   read-modify-write through S_FREE_RD and S_FREE_WR. An invalid free, or
//   an allocate with limit zero, answers straight from idle; busy does not rise.
//   Otherwise busy stays high until the result strobe.
// Reset
//   Synchronous reset clears the counter and sets the config to its defaults,
//   then a clearing pass writes zero to every bitmap word, MAP_BITS / 32 words
//   (rounded up), with busy high. Config writes are taken during the pass.

module bitmap_first_fit_allocator #(
  parameter int MAP_BITS = 8192
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // command channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_kind,
  input  wire logic [bfa_pkg::FIELD_W-1:0]       in_index,
  // result channel
  output logic                                   out_valid,
  output logic [bfa_pkg::STATUS_W-1:0]           out_status,
  output logic [bfa_pkg::FIELD_W-1:0]            out_index_res,
  output logic [bfa_pkg::FIELD_W-1:0]            out_used_count,
  // config channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bfa_pkg::FIELD_W-1:0]       cfg_wdata
);

  import bfa_pkg::*;

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LW        = $clog2(MAP_BITS + 1);
  localparam int CW        = (LW > FIELD_W) ? LW : FIELD_W;
  localparam logic [WW-1:0] LAST_RAM_WORD = WW'(MAP_WORDS - 1);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [FIELD_W-1:0] entry_count_r;
  logic               number_base_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= ENTRY_COUNT_RST;
      number_base_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata;
        CFG_NUMBER_BASE: number_base_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective limit: entry_count saturated at the map size
  logic [CW-1:0] ec_ext;
  logic [CW-1:0] lim_ext;
  logic [LW-1:0] lim_m1;
  logic [WW-1:0] last_word;
  logic          lim_zero;

  always_comb begin
    ec_ext    = CW'(entry_count_r);
    lim_ext   = (ec_ext > CW'(MAP_BITS)) ? CW'(MAP_BITS) : ec_ext;
    lim_zero  = (lim_ext == '0);
    lim_m1    = LW'(lim_ext - CW'(1));
    last_word = WW'(lim_m1 >> BIT_W);
  end

  // Free request decode
  logic [FIELD_W-1:0] free_pos;
  logic [CW-1:0]      free_pos_ext;
  logic               free_bad;

  always_comb begin
    free_pos     = in_index - FIELD_W'(number_base_r);
    free_pos_ext = CW'(free_pos);
    free_bad     = (in_index == '0) || (FIELD_W'(number_base_r) > in_index) ||
                   (free_pos_ext >= lim_ext);
  end

  // ---------------------------------------------------------------
  // Bitmap RAM
  // ---------------------------------------------------------------
  logic                 ram_we;
  logic [WW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (WW)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------
  bfa_state_t         state_r,       state_nxt;
  logic [WW-1:0]      clr_ptr_r,     clr_ptr_nxt;
  logic [WW-1:0]      scan_ptr_r,    scan_ptr_nxt;
  logic [WW-1:0]      data_ptr_r,    data_ptr_nxt;
  logic               data_vld_r,    data_vld_nxt;
  logic [WW-1:0]      free_word_r,   free_word_nxt;
  logic [BIT_W-1:0]   free_bit_r,    free_bit_nxt;
  logic [FIELD_W-1:0] used_r,        used_nxt;
  logic               out_valid_r,   out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [FIELD_W-1:0] out_index_r,   out_index_nxt;

  // Find-first-zero over the word that came back from the RAM
  logic [WORD_BITS-1:0] elig;
  logic [WORD_BITS-1:0] free_bits;
  logic                 hit;
  logic [BIT_W-1:0]     hit_bit;
  logic [31:0]          alloc_num;

  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      // on the last word, mask bits at or beyond the limit
      elig[b] = (data_ptr_r != last_word) || (BIT_W'(b) <= lim_m1[BIT_W-1:0]);
    end
    free_bits = ~ram_rdata & elig;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit     = 1'b1;
        hit_bit = BIT_W'(b);
      end
    end
    alloc_num = 32'({data_ptr_r, hit_bit}) + 32'(number_base_r);
  end

  // Next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    clr_ptr_nxt    = clr_ptr_r;
    scan_ptr_nxt   = scan_ptr_r;
    data_ptr_nxt   = data_ptr_r;
    data_vld_nxt   = data_vld_r;
    free_word_nxt  = free_word_r;
    free_bit_nxt   = free_bit_r;
    used_nxt       = used_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    ram_we         = 1'b0;
    ram_waddr      = clr_ptr_r;
    ram_wdata      = '0;
    ram_raddr      = scan_ptr_r;

    unique case (state_r)
      S_CLEAR: begin
        // zero one word per cycle
        ram_we      = 1'b1;
        ram_waddr   = clr_ptr_r;
        clr_ptr_nxt = WW'(clr_ptr_r + WW'(1));
        if (clr_ptr_r == LAST_RAM_WORD) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          if (in_kind == KIND_ALLOC) begin
            if (lim_zero) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_FULL;
              out_index_nxt  = '0;
            end else begin
              scan_ptr_nxt = '0;
              data_vld_nxt = 1'b0;
              state_nxt    = S_SCAN;
            end
          end else begin
            if (free_bad) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_INVALID;
              out_index_nxt  = '0;
            end else begin
              free_word_nxt = WW'(free_pos_ext >> BIT_W);
              free_bit_nxt  = free_pos[BIT_W-1:0];
              state_nxt     = S_FREE_RD;
            end
          end
        end
      end

      S_SCAN: begin
        // issue the next read while the previous word is examined
        ram_raddr    = scan_ptr_r;
        data_ptr_nxt = scan_ptr_r;
        data_vld_nxt = 1'b1;
        if (scan_ptr_r != last_word) begin
          scan_ptr_nxt = WW'(scan_ptr_r + WW'(1));
        end
        if (data_vld_r) begin
          if (hit) begin
            ram_we         = 1'b1;
            ram_waddr      = data_ptr_r;
            ram_wdata      = ram_rdata | (WORD_BITS'(1) << hit_bit);
            used_nxt       = (used_r == COUNT_MAX) ? used_r : FIELD_W'(used_r + FIELD_W'(1));
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_index_nxt  = alloc_num[FIELD_W-1:0];
            state_nxt      = S_IDLE;
          end else if (data_ptr_r == last_word) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
            out_index_nxt  = '0;
            state_nxt      = S_IDLE;
          end
        end
      end

      S_FREE_RD: begin
        ram_raddr = free_word_r;
        state_nxt = S_FREE_WR;
      end

      S_FREE_WR: begin
        // clear the bit; the counter drops even if it was already clear
        ram_we         = 1'b1;
        ram_waddr      = free_word_r;
        ram_wdata      = ram_rdata & ~(WORD_BITS'(1) << free_bit_r);
        used_nxt       = (used_r == '0) ? used_r : FIELD_W'(used_r - FIELD_W'(1));
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_index_nxt  = '0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ptr_r   <= '0;
      scan_ptr_r  <= '0;
      data_vld_r  <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      data_vld_r  <= data_vld_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    data_ptr_r   <= data_ptr_nxt;
    free_word_r  <= free_word_nxt;
    free_bit_r   <= free_bit_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_index_res  = out_index_r;
  assign out_used_count = used_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_alloc_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind == KIND_ALLOC) && !lim_zero) |=> busy)
    else $error("allocate accepted but sequencer did not go busy");

  a_fail_has_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_index_res == '0))
    else $error("failed request returned a nonzero entry number");

  a_count_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(used_r) |-> (out_valid_r &&
      ((used_r == FIELD_W'($past(used_r) + FIELD_W'(1))) ||
       (used_r == FIELD_W'($past(used_r) - FIELD_W'(1))))))
    else $error("use counter moved without a result or by more than one");

  a_scan_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && data_vld_r) |-> (data_ptr_r <= last_word))
    else $error("scan examined a word beyond the entry limit");

endmodule : bitmap_first_fit_allocator

`default_nettype wire

>>> hdl/bfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule : bfa_ram

`default_nettype wire
